// ----- rtl/core/lwed_pkg.sv -----
`timescale 1ns / 1ps
package lwed_pkg;
    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int RULE_SLOTS_DEF   = 16;
    localparam int HANDLE_SLOTS_DEF = 32;
    localparam int SAMPLE_W         = 24;
    localparam int ID_W             = 31;
    localparam int REFS_W           = 6;
    localparam int WAKE_W           = 16;

    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_CREATE  = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;
    localparam logic [1:0] OP_DESTROY = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
endpackage

// ----- rtl/core/light_window_event_detector.sv -----
`timescale 1ns / 1ps
// Light window event detector. One beat in, one beat out, one item at a time. The
// sample window is a chain of cells that rotates once through all WINDOW_DEPTH cells
// for every sample and query beat, counting hits for all rules in parallel. A query then
// scans the handle table; create scans the rule and handle tables and destroy the
// handle table, without a rotation. The result sits in an output register; a result
// not yet taken does not block the next beat and only holds the core in its done
// state until it is taken.
module light_window_event_detector #(
    parameter int WINDOW_DEPTH = lwed_pkg::WINDOW_DEPTH_DEF,
    parameter int RULE_SLOTS   = lwed_pkg::RULE_SLOTS_DEF,
    parameter int HANDLE_SLOTS = lwed_pkg::HANDLE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [1:0]  operation,
    input  logic [23:0] sample_intensity,
    input  logic signed [24:0] required_intensity,
    input  logic [7:0]  required_count,
    input  logic [30:0] handle_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [30:0] new_id,
    output logic        occurred,
    output logic [15:0] wake_mask,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    import lwed_pkg::*;

    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int HW  = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
    localparam int RW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int SCAN = (RULE_SLOTS > HANDLE_SLOTS) ? RULE_SLOTS : HANDLE_SLOTS;
    localparam int SW  = $clog2(SCAN + WINDOW_DEPTH + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [SW-1:0] cnt_reg;

    logic [1:0]  op_reg;
    logic        neg_reg;
    logic [23:0] thr_reg;
    logic [CW-1:0] need_reg;
    logic        cnt_zero_reg;
    logic [30:0] id_reg;

    logic [23:0] tol_reg;

    logic [SAMPLE_W-1:0] chain_d [WINDOW_DEPTH+1];
    logic                chain_v [WINDOW_DEPTH+1];
    logic                shift_en, push;

    logic [23:0]   rthr_reg  [RULE_SLOTS];
    logic [CW-1:0] rneed_reg [RULE_SLOTS];
    logic [REFS_W-1:0] rrefs_reg [RULE_SLOTS];
    logic [CW-1:0] hits_reg  [RULE_SLOTS];

    logic          hval_reg  [HANDLE_SLOTS];
    logic [30:0]   hid_reg   [HANDLE_SLOTS];
    logic [RW-1:0] hslot_reg [HANDLE_SLOTS];
    logic [30:0]   last_id_reg;

    // scan results
    logic          m_found_reg, f_found_reg, h_found_reg, k_found_reg;
    logic [RW-1:0] m_idx_reg, f_idx_reg;
    logic [HW-1:0] h_idx_reg, k_idx_reg;

    logic        ov_reg;
    logic [1:0]  st_reg;
    logic [30:0] nid_reg;
    logic        occ_reg;
    logic [15:0] wk_reg;

    logic [RW-1:0] ri;
    logic [HW-1:0] hi;

    logic          done_go;
    logic          create_ok;
    logic [RW-1:0] k_slot;
    logic [1:0]    st_next;
    logic [30:0]   nid_next;
    logic          occ_next;
    logic [15:0]   wk_next;

    assign ready     = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign new_id    = nid_reg;
    assign occurred  = occ_reg;
    assign wake_mask = wk_reg;

    assign done_go = (state_reg == S_DONE) && (!ov_reg || out_ready);

    // chain: cell 0 takes either the new sample or the wrap from the last cell
    assign push     = (state_reg == S_IDLE) && valid && ready && (operation == OP_SAMPLE);
    assign shift_en = push || (state_reg == S_ROT);
    assign chain_d[0] = push ? sample_intensity : chain_d[WINDOW_DEPTH];
    assign chain_v[0] = push ? 1'b1 : chain_v[WINDOW_DEPTH];

    genvar g;
    generate
        for (g = 0; g < WINDOW_DEPTH; g++)
        begin : g_cell
            lwed_window_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .data_in  (chain_d[g]),
                .vld_in   (chain_v[g]),
                .data_out (chain_d[g+1]),
                .vld_out  (chain_v[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        ri = RW'(cnt_reg);
        hi = HW'(cnt_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (valid && ready)
                    state_next = (operation == OP_SAMPLE || operation == OP_QUERY) ? S_ROT
                                                                                   : S_SCAN;
            S_ROT:
                if (cnt_reg == SW'(WINDOW_DEPTH - 1))
                    state_next = (op_reg == OP_QUERY) ? S_SCAN : S_DONE;
            S_SCAN:
                if (cnt_reg == SW'(SCAN - 1))
                    state_next = S_DONE;
            S_DONE:
                if (done_go)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // result of the finished beat
    always_comb
    begin
        k_slot    = hslot_reg[k_idx_reg];
        create_ok = !neg_reg && !cnt_zero_reg && last_id_reg != ID_MAX && h_found_reg
                    && (m_found_reg ? (rrefs_reg[m_idx_reg] != {REFS_W{1'b1}})
                                    : f_found_reg);
        st_next  = ST_OK;
        nid_next = '0;
        occ_next = 1'b0;
        wk_next  = '0;
        unique case (op_reg)
            OP_SAMPLE:
                for (int r = 0; r < RULE_SLOTS && r < WAKE_W; r++)
                    wk_next[r] = (rrefs_reg[r] != '0) && (hits_reg[r] >= rneed_reg[r]);
            OP_CREATE:
                if (neg_reg || cnt_zero_reg)
                    st_next = ST_INVALID;
                else if (!create_ok)
                    st_next = ST_FULL;
                else
                    nid_next = last_id_reg + 1'b1;
            OP_QUERY:
                if (!k_found_reg)
                    st_next = ST_INVALID;
                else
                    occ_next = hits_reg[k_slot] >= rneed_reg[k_slot];
            OP_DESTROY:
                if (!k_found_reg)
                    st_next = ST_INVALID;
                else if (32'(k_slot) < WAKE_W)
                    wk_next = WAKE_W'(1) << k_slot;
            default:
                st_next = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            tol_reg     <= '0;
            last_id_reg <= '0;
            ov_reg      <= 1'b0;
            for (int r = 0; r < RULE_SLOTS; r++)
                rrefs_reg[r] <= '0;
            for (int h = 0; h < HANDLE_SLOTS; h++)
                hval_reg[h] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                tol_reg <= cfg_data;
            if (done_go)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;

            if (done_go)
            begin
                if (op_reg == OP_CREATE && create_ok)
                begin
                    last_id_reg <= last_id_reg + 1'b1;
                    hval_reg[h_idx_reg] <= 1'b1;
                    if (m_found_reg)
                        rrefs_reg[m_idx_reg] <= rrefs_reg[m_idx_reg] + 1'b1;
                    else
                        rrefs_reg[f_idx_reg] <= REFS_W'(1);
                end
                if (op_reg == OP_DESTROY && k_found_reg)
                begin
                    hval_reg[k_idx_reg] <= 1'b0;
                    if (rrefs_reg[k_slot] != '0)
                        rrefs_reg[k_slot] <= rrefs_reg[k_slot] - 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && valid && ready)
        begin
            op_reg       <= operation;
            neg_reg      <= required_intensity[24];
            thr_reg      <= required_intensity[23:0];
            cnt_zero_reg <= (required_count == 8'd0);
            need_reg     <= (required_count > 8'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH)
                                                                : CW'(required_count);
            id_reg       <= handle_id;
            m_found_reg  <= 1'b0;
            f_found_reg  <= 1'b0;
            h_found_reg  <= 1'b0;
            k_found_reg  <= 1'b0;
            for (int r = 0; r < RULE_SLOTS; r++)
                hits_reg[r] <= '0;
        end

        if (state_reg == S_ROT)
        begin
            for (int r = 0; r < RULE_SLOTS; r++)
                if (chain_v[WINDOW_DEPTH] &&
                    ({1'b0, chain_d[WINDOW_DEPTH]} + {1'b0, tol_reg} >= {1'b0, rthr_reg[r]}))
                    hits_reg[r] <= hits_reg[r] + 1'b1;
        end

        if (state_reg == S_SCAN)
        begin
            if (op_reg != OP_CREATE && cnt_reg < SW'(HANDLE_SLOTS) && !k_found_reg
                && hval_reg[hi] && hid_reg[hi] == id_reg && id_reg != '0)
            begin
                k_found_reg <= 1'b1;
                k_idx_reg   <= hi;
            end
            if (op_reg == OP_CREATE && cnt_reg < SW'(HANDLE_SLOTS) && !h_found_reg
                && !hval_reg[hi])
            begin
                h_found_reg <= 1'b1;
                h_idx_reg   <= hi;
            end
            if (op_reg == OP_CREATE && cnt_reg < SW'(RULE_SLOTS))
            begin
                if (rrefs_reg[ri] != '0)
                begin
                    if (!m_found_reg && rthr_reg[ri] == thr_reg && rneed_reg[ri] == need_reg)
                    begin
                        m_found_reg <= 1'b1;
                        m_idx_reg   <= ri;
                    end
                end
                else if (!f_found_reg)
                begin
                    f_found_reg <= 1'b1;
                    f_idx_reg   <= ri;
                end
            end
        end

        if (done_go)
        begin
            st_reg  <= st_next;
            nid_reg <= nid_next;
            occ_reg <= occ_next;
            wk_reg  <= wk_next;
            if (op_reg == OP_CREATE && create_ok)
            begin
                hid_reg[h_idx_reg]   <= nid_next;
                hslot_reg[h_idx_reg] <= m_found_reg ? m_idx_reg : f_idx_reg;
                if (!m_found_reg)
                begin
                    rthr_reg[f_idx_reg]  <= thr_reg;
                    rneed_reg[f_idx_reg] <= need_reg;
                end
            end
        end
    end
endmodule

// ----- rtl/core/lwed_window_cell.sv -----
`timescale 1ns / 1ps
module lwed_window_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic [lwed_pkg::SAMPLE_W-1:0] data_in,
    input  logic                          vld_in,
    output logic [lwed_pkg::SAMPLE_W-1:0] data_out,
    output logic                          vld_out
);
    import lwed_pkg::*;

    logic [SAMPLE_W-1:0] data_reg;
    logic                vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (shift_en)
            vld_reg <= vld_in;
    end

    // payload needs no reset, vld marks it
    always_ff @(posedge clk)
    begin
        if (shift_en)
            data_reg <= data_in;
    end

    assign data_out = data_reg;
    assign vld_out  = vld_reg;
endmodule

// ----- verif/light_window_event_detector_tb.sv -----
`timescale 1ns / 1ps
module light_window_event_detector_tb;
    import lwed_pkg::*;

    localparam int DEPTH = 16;
    localparam int RULES = 16;
    localparam int HANDLES = 32;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] new_id;
        logic        occurred;
        logic [15:0] wake_mask;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        ready;
    logic [1:0]  operation = OP_SAMPLE;
    logic [23:0] sample_intensity = '0;
    logic signed [24:0] required_intensity = '0;
    logic [7:0]  required_count = '0;
    logic [30:0] handle_id = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [30:0] new_id;
    logic        occurred;
    logic [15:0] wake_mask;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;

    light_window_event_detector uut (
        .clk(clk), .rst_n(rst_n),
        .valid(valid), .ready(ready),
        .operation(operation), .sample_intensity(sample_intensity),
        .required_intensity(required_intensity), .required_count(required_count),
        .handle_id(handle_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .new_id(new_id), .occurred(occurred), .wake_mask(wake_mask),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // detector shadow state
    logic [23:0] win_smp [DEPTH];
    int unsigned win_fill, win_head;
    logic [23:0] rule_thr [RULES];
    int unsigned rule_cnt [RULES];
    int unsigned rule_users [RULES];
    bit          hnd_live [HANDLES];
    logic [30:0] hnd_id [HANDLES];
    int unsigned hnd_rule [HANDLES];
    logic [30:0] last_id;
    logic [23:0] tolerance;

    verdict_t pending_verdicts[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int wakes_seen = 0;
    int holds_seen = 0;
    int full_seen = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int stall_left = 0;

    function automatic bit rule_met(int unsigned r);
        int unsigned hits;
        logic [24:0] sum;
        hits = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i < win_fill) begin
                sum = {1'b0, win_smp[i]} + {1'b0, tolerance};
                if (sum >= {1'b0, rule_thr[r]})
                    hits++;
            end
        end
        return hits >= rule_cnt[r];
    endfunction

    function automatic void predict(logic [1:0] op, logic [23:0] smp, logic [24:0] req,
                                    logic [7:0] cnt, logic [30:0] id);
        verdict_t v;
        int match, free_rule, free_hnd, h;
        int unsigned need;
        v = '0;
        if (op == OP_SAMPLE) begin
            win_smp[win_head] = smp;
            win_head = (win_head + 1) % DEPTH;
            if (win_fill < DEPTH)
                win_fill++;
            for (int r = 0; r < RULES; r++)
                if (rule_users[r] != 0 && rule_met(r))
                    v.wake_mask[r] = 1'b1;
        end else if (op == OP_CREATE) begin
            if (req[24] || cnt == 0) begin
                v.status = ST_INVALID;
            end else begin
                need = (cnt > DEPTH) ? DEPTH : cnt;
                match = -1;
                free_rule = -1;
                free_hnd = -1;
                for (int r = 0; r < RULES; r++) begin
                    if (rule_users[r] != 0) begin
                        if (match < 0 && rule_thr[r] == req[23:0] && rule_cnt[r] == need)
                            match = r;
                    end else if (free_rule < 0) begin
                        free_rule = r;
                    end
                end
                for (int k = HANDLES - 1; k >= 0; k--)
                    if (!hnd_live[k])
                        free_hnd = k;
                if (last_id == ID_MAX || free_hnd < 0)
                    v.status = ST_FULL;
                else if (match < 0 && free_rule < 0)
                    v.status = ST_FULL;
                else if (match >= 0 && rule_users[match] >= 63)
                    v.status = ST_FULL;
                else begin
                    if (match < 0) begin
                        match = free_rule;
                        rule_thr[match] = req[23:0];
                        rule_cnt[match] = need;
                        rule_users[match] = 0;
                    end
                    rule_users[match]++;
                    last_id++;
                    hnd_live[free_hnd] = 1'b1;
                    hnd_id[free_hnd] = last_id;
                    hnd_rule[free_hnd] = match;
                    v.new_id = last_id;
                end
            end
        end else begin
            h = -1;
            if (id != 0)
                for (int k = 0; k < HANDLES; k++)
                    if (h < 0 && hnd_live[k] && hnd_id[k] == id)
                        h = k;
            if (h < 0) begin
                v.status = ST_INVALID;
            end else if (op == OP_QUERY) begin
                v.occurred = rule_met(hnd_rule[h]);
            end else begin
                hnd_live[h] = 1'b0;
                if (rule_users[hnd_rule[h]] != 0)
                    rule_users[hnd_rule[h]]--;
                v.wake_mask[hnd_rule[h]] = 1'b1;
            end
        end
        pending_verdicts.push_back(v);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, results_seen);
        errors++;
    endtask

    // result side: random stall per beat
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
        if (out_valid && out_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report("unexpected beat", 0, 0);
            end else begin
                verdict_t want;
                want = pending_verdicts.pop_front();
                if (status !== want.status) report("status", status, want.status);
                if (new_id !== want.new_id) report("new_id", new_id, want.new_id);
                if (occurred !== want.occurred) report("occurred", occurred, want.occurred);
                if (wake_mask !== want.wake_mask) report("wake_mask", wake_mask, want.wake_mask);
                if (want.wake_mask != 0) wakes_seen++;
                if (want.occurred) holds_seen++;
                if (want.status == ST_FULL) full_seen++;
            end
            stall_left = quiet ? 0 : $urandom_range(0, 17);
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(logic [1:0] op, logic [23:0] smp, logic [24:0] req,
                             logic [7:0] cnt, logic [30:0] id);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid <= 1'b1;
        operation <= op;
        sample_intensity <= smp;
        required_intensity <= req;
        required_count <= cnt;
        handle_id <= id;
        do @(posedge clk); while (!ready);
        predict(op, smp, req, cnt, id);
        items_sent++;
    endtask

    task automatic drain();
        valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [23:0] t);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= t;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tolerance = t;
        @(posedge clk);
    endtask

    function automatic logic [30:0] live_id();
        int picks[$];
        for (int k = 0; k < HANDLES; k++)
            if (hnd_live[k]) picks.push_back(k);
        if (picks.size() == 0) return 31'd0;
        return hnd_id[picks[$urandom_range(0, picks.size() - 1)]];
    endfunction

    task automatic test_directed();
        send_item(OP_QUERY, 24'h0, 25'h0, 8'd0, 31'd0);
        send_item(OP_DESTROY, 24'hFFFFFF, 25'h0, 8'd1, 31'h7FFFFFFF);
        send_item(OP_CREATE, 24'h0, 25'h1FFFFFF, 8'd1, 31'd0);
        send_item(OP_CREATE, 24'h0, 25'h1000000, 8'd4, 31'd0);
        send_item(OP_CREATE, 24'h0, 25'h000100, 8'd0, 31'd0);
        send_item(OP_CREATE, 24'h0, 25'h000000, 8'd1, 31'd0);
        send_item(OP_CREATE, 24'h0, 25'h0FFFFFF, 8'd255, 31'd0);
        send_item(OP_CREATE, 24'h0, 25'h0FFFFFF, 8'd16, 31'd0);
        send_item(OP_CREATE, 24'h0, 25'h000800, 8'd2, 31'd0);
        send_item(OP_QUERY, 24'h0, 25'h0, 8'd0, 31'd1);
        send_item(OP_SAMPLE, 24'h000000, 25'h0, 8'd0, 31'd0);
        send_item(OP_SAMPLE, 24'hFFFFFF, 25'h0, 8'd0, 31'd0);
        send_item(OP_SAMPLE, 24'h000900, 25'h0, 8'd0, 31'd0);
        send_item(OP_QUERY, 24'h0, 25'h0, 8'd0, 31'd1);
        send_item(OP_QUERY, 24'h0, 25'h0, 8'd0, 31'd2);
        send_item(OP_QUERY, 24'h0, 25'h0, 8'd0, 31'd4);
        send_item(OP_DESTROY, 24'h0, 25'h0, 8'd0, 31'd3);
        send_item(OP_DESTROY, 24'h0, 25'h0, 8'd0, 31'd3);
        send_item(OP_QUERY, 24'h0, 25'h0, 8'd0, 31'd3);
        send_item(OP_SAMPLE, 24'hFFFFFF, 25'h0, 8'd0, 31'd0);
    endtask

    task automatic test_table_limits();
        // distinct rules until slots run out, then shared handles until handles run out
        for (int i = 0; i < RULES + 2; i++)
            send_item(OP_CREATE, 24'h0, {1'b0, 24'(i * 97 + 5)}, 8'd3, 31'd0);
        for (int i = 0; i < HANDLES; i++)
            send_item(OP_CREATE, 24'h0, 25'd5, 8'd3, 31'd0);
        for (int i = 0; i < 20; i++)
            send_item(OP_SAMPLE, 24'($urandom_range(0, 2000)), 25'h0, 8'd0, 31'd0);
        for (int k = 0; k < HANDLES; k++)
            if (hnd_live[k])
                send_item(OP_DESTROY, 24'h0, 25'h0, 8'd0, hnd_id[k]);
    endtask

    task automatic test_random(int n);
        int pick;
        logic [24:0] req;
        logic [7:0] cnt;
        logic [30:0] id;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            req = {1'b0, 24'($urandom_range(0, 8) * 500)};
            cnt = 8'($urandom_range(1, 18));
            if ($urandom_range(0, 9) == 0) req = 25'($urandom);
            if ($urandom_range(0, 9) == 0) cnt = 8'($urandom);
            id = ($urandom_range(0, 7) == 0) ? 31'($urandom) : live_id();
            if (pick < 40)
                send_item(OP_SAMPLE, ($urandom_range(0, 7) == 0) ? 24'($urandom)
                          : 24'($urandom_range(0, 4500)), 25'($urandom), 8'($urandom), 31'($urandom));
            else if (pick < 60)
                send_item(OP_CREATE, 24'($urandom), req, cnt, 31'($urandom));
            else if (pick < 82)
                send_item(OP_QUERY, 24'($urandom), 25'($urandom), 8'($urandom), id);
            else
                send_item(OP_DESTROY, 24'($urandom), 25'($urandom), 8'($urandom), id);
        end
    endtask

    initial begin
        win_fill = 0;
        win_head = 0;
        last_id = '0;
        tolerance = '0;
        for (int r = 0; r < RULES; r++) rule_users[r] = 0;
        for (int k = 0; k < HANDLES; k++) hnd_live[k] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_limits();
        set_tolerance(24'hFFFFFF);
        test_random(200);
        set_tolerance(24'd0);
        quiet = 1'b1;
        test_random(150);
        quiet = 1'b0;
        test_random(150);
        set_tolerance(24'($urandom_range(1, 1500)));
        test_random(250);
        set_tolerance(24'($urandom));
        test_random(250);
        drain();
        $display("covered %0d items, %0d results: %0d with wakes, %0d rule holds, %0d full",
                 items_sent, results_seen, wakes_seen, holds_seen, full_seen);
        $display("tolerance swept 0, max and random values; %0d errors", errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
